/* hdl/i2cra_pkg.sv */
// Package for the I2C register access master sequencer.
// Holds the item types, command and status codes and register map.
// Depends on nothing; every other file of the block imports it.
package i2cra_pkg;

  // Input item commands.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_TICK  = 2'd3
  } command_t;

  // Operation status as reported in every result item.
  localparam logic [1:0] OP_BUSY  = 2'd0;
  localparam logic [1:0] OP_OK    = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  // Transfer phase of the current operation.
  typedef enum logic [3:0] {
    PH_DUMMY = 4'b0001,
    PH_LOWER = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // Bus controller status codes.
  localparam logic [7:0] BS_START      = 8'h08;
  localparam logic [7:0] BS_REP_START  = 8'h10;
  localparam logic [7:0] BS_SLAW_ACK   = 8'h18;
  localparam logic [7:0] BS_SLAW_NACK  = 8'h20;
  localparam logic [7:0] BS_DATA_ACK   = 8'h28;
  localparam logic [7:0] BS_DATA_NACK  = 8'h30;
  localparam logic [7:0] BS_SLAR_ACK   = 8'h40;
  localparam logic [7:0] BS_SLAR_NACK  = 8'h48;
  localparam logic [7:0] BS_RX_NACK    = 8'h58;

  // Address byte direction bit handling.
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        REG_TIMEOUT   = 1'b0;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  typedef struct packed {
    command_t   command;
    logic [7:0] device_addr;
    logic [7:0] storage_addr;
    logic [7:0] write_data;
    logic [7:0] bus_status;
    logic [7:0] rx_data;
  } cmd_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       start_request;
    logic       start_clear;
    logic       stop_request;
    logic [1:0] op_status;
    logic [7:0] read_data;
    logic       events_masked;
  } res_item_t;

endpackage

/* hdl/i2cra_if.sv */
// Valid/ready channel interfaces for the sequencer's input and result items.
// Depends on i2cra_pkg for the item types.
interface i2cra_cmd_if;
  import i2cra_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cra_res_if;
  import i2cra_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/i2c_register_access_master_sequencer_core.sv */
// Top level of the I2C register access master sequencer.
// Depends on i2cra_pkg and on the channel interfaces in i2cra_if.sv.
//
// This block sequences a one-byte I2C register write, or a register read made of a dummy
// write followed by a repeated start. Each input item is a start read, a start write, a bus
// controller status event or a millisecond tick, and every input item yields exactly one
// result item: the byte to load for transmission, start, start-clear and stop requests, the
// operation status, the data byte and the event mask flag. Each item is decoded by a case
// on the command and status code straight into the result register, so one item can be
// accepted in every cycle while the skid register is free, and the result is registered. A
// skid register behind the result register lets one further item
// be taken while a result waits; input ready drops only when both are full. The retry
// timeout is set through the APB port (register 0 at byte address 0, 16 bits, reset 60) and
// should only be written while no item is in flight.
module i2c_register_access_master_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  i2cra_cmd_if.sink                           cmd,
  i2cra_res_if.source                         res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cra_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import i2cra_pkg::*;

  // Configuration register.
  logic [TIMEOUT_W-1:0] timeout_ticks;

  // Sequencer state.
  logic [7:0]           dev_addr_reg, dev_addr_reg_next;
  logic [7:0]           reg_addr_reg, reg_addr_reg_next;
  logic [7:0]           data_reg, data_reg_next;
  logic                 is_read, is_read_next;
  phase_t               phase, phase_next;
  logic [1:0]           op_state, op_state_next;
  logic [TIMEOUT_W-1:0] timeout_count, timeout_count_next;
  logic                 events_enabled, events_enabled_next;

  // Result path: the output register and one skid register behind it.
  res_item_t            result_next;
  res_item_t            out_item, skid_item;
  logic                 out_valid, skid_valid;
  logic                 in_accept, out_take;

  cmd_item_t            item;
  assign item = cmd.payload;

  // The APB port never waits. The register sits at word 0; higher words read as zero.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {{(32-TIMEOUT_W){1'b0}}, timeout_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[TIMEOUT_W-1:0];
    end
  end

  // Handshakes. A new item is refused only while the skid register is occupied.
  assign cmd.ready  = !skid_valid;
  assign in_accept  = cmd.valid && !skid_valid;
  assign out_take   = out_valid && res.ready;
  assign res.valid  = out_valid;
  assign res.payload = out_item;

  // Decode of one item: next state and the result fields.
  always_comb begin
    dev_addr_reg_next   = dev_addr_reg;
    reg_addr_reg_next   = reg_addr_reg;
    data_reg_next       = data_reg;
    is_read_next        = is_read;
    phase_next          = phase;
    op_state_next       = op_state;
    timeout_count_next  = timeout_count;
    events_enabled_next = events_enabled;
    result_next         = '0;

    unique case (item.command)
      CMD_READ: begin
        op_state_next     = OP_BUSY;
        dev_addr_reg_next = item.device_addr;
        reg_addr_reg_next = item.storage_addr;
        is_read_next      = 1'b1;
        phase_next        = PH_DUMMY;
        result_next.start_request = 1'b1;
      end
      CMD_WRITE: begin
        // The phase is left alone here; the address acknowledge moves it on anyway.
        dev_addr_reg_next = item.device_addr;
        reg_addr_reg_next = item.storage_addr;
        data_reg_next     = item.write_data;
        op_state_next     = OP_BUSY;
        is_read_next      = 1'b0;
        result_next.start_request = 1'b1;
      end
      CMD_TICK: begin
        // The millisecond counter saturates at zero.
        if (timeout_count != '0) begin
          timeout_count_next = timeout_count - TIMEOUT_W'(1);
        end
      end
      CMD_EVENT: begin
        // Once an unknown status has been seen, events are ignored altogether.
        if (events_enabled) begin
          case (item.bus_status) inside
            BS_START: begin
              result_next.start_clear = 1'b1;
              result_next.tx_valid    = 1'b1;
              result_next.tx_byte     = dev_addr_reg & ADDR_WR_MASK;
              timeout_count_next      = timeout_ticks;
            end
            BS_REP_START: begin
              // The repeated start after the dummy write addresses the device for reading.
              result_next.start_clear = 1'b1;
              result_next.tx_valid    = 1'b1;
              if (is_read && phase != PH_DUMMY) begin
                result_next.tx_byte = dev_addr_reg | ADDR_RD_BIT;
              end else begin
                result_next.tx_byte = dev_addr_reg & ADDR_WR_MASK;
              end
            end
            BS_SLAW_ACK: begin
              result_next.tx_valid = 1'b1;
              result_next.tx_byte  = reg_addr_reg;
              phase_next           = PH_DATA;
            end
            BS_SLAW_NACK: begin
              // An address NACK is retried with a repeated start until the time runs out.
              if (timeout_count == '0) begin
                result_next.stop_request = 1'b1;
                op_state_next            = OP_ERROR;
              end else begin
                result_next.start_request = 1'b1;
              end
            end
            BS_DATA_ACK: begin
              unique case (phase)
                PH_LOWER: begin
                  result_next.tx_valid = 1'b1;
                  result_next.tx_byte  = reg_addr_reg;
                  phase_next           = PH_DATA;
                end
                PH_DATA: begin
                  if (is_read) begin
                    result_next.start_request = 1'b1;
                  end else begin
                    result_next.tx_valid = 1'b1;
                    result_next.tx_byte  = data_reg;
                    phase_next           = PH_DONE;
                  end
                end
                PH_DONE: begin
                  result_next.stop_request = 1'b1;
                  op_state_next            = OP_OK;
                end
                default: begin
                  // Data acknowledge during the dummy write needs no action.
                end
              endcase
            end
            BS_DATA_NACK, BS_SLAR_NACK: begin
              result_next.stop_request = 1'b1;
              op_state_next            = OP_ERROR;
            end
            BS_SLAR_ACK: begin
              // Read address acknowledged; the controller clocks in the byte on its own.
            end
            BS_RX_NACK: begin
              data_reg_next            = item.rx_data;
              op_state_next            = OP_OK;
              result_next.stop_request = 1'b1;
            end
            default: begin
              result_next.stop_request = 1'b1;
              op_state_next            = OP_ERROR;
              events_enabled_next      = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    result_next.op_status     = op_state_next;
    result_next.read_data     = data_reg_next;
    result_next.events_masked = !events_enabled_next;
  end

  // State registers change only when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr_reg   <= '0;
      reg_addr_reg   <= '0;
      data_reg       <= '0;
      is_read        <= 1'b0;
      phase          <= PH_DUMMY;
      op_state       <= OP_BUSY;
      timeout_count  <= '0;
      events_enabled <= 1'b1;
    end else if (in_accept) begin
      dev_addr_reg   <= dev_addr_reg_next;
      reg_addr_reg   <= reg_addr_reg_next;
      data_reg       <= data_reg_next;
      is_read        <= is_read_next;
      phase          <= phase_next;
      op_state       <= op_state_next;
      timeout_count  <= timeout_count_next;
      events_enabled <= events_enabled_next;
    end
  end

  // Result register and skid register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_item <= skid_item;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_item <= result_next;
      end else begin
        out_item <= result_next;
      end
    end
  end

  // The skid register is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the result register is empty");

  // No transmit byte is offered unless it is to be loaded.
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'h00)
    else $error("tx_byte nonzero without tx_valid");

  // A start and a stop are never requested by the same item.
  a_start_stop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.start_request && out_item.stop_request))
    else $error("start and stop requested together");

  // Masking of events is permanent until reset.
  a_mask_sticky: assert property (@(posedge clk) disable iff (rst)
    !events_enabled |=> !events_enabled)
    else $error("events re-enabled without reset");

  // The timeout counter only grows when a start condition loads it.
  a_timeout_load: assert property (@(posedge clk) disable iff (rst)
    in_accept && timeout_count_next > timeout_count |->
      item.command == CMD_EVENT && item.bus_status == BS_START)
    else $error("timeout counter increased without a start condition");

endmodule

/* tb/i2cra_checker.sv */
`timescale 1ns / 1ps
// Result checker for the I2C register access master sequencer.
// Depends on i2cra_pkg and the channel interfaces; watches the APB port for timeout writes.
module i2cra_checker (
  input  logic                             clk,
  input  logic                             rst,
  i2cra_cmd_if                             cmd,
  i2cra_res_if                             res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [i2cra_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output int unsigned                      fail_count,
  output int unsigned                      backlog,
  output int unsigned                      results_seen
);
  import i2cra_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'({REG_TIMEOUT, 2'b00});

  // Shadow copy of the sequencer's state and its timeout register.
  logic [TIMEOUT_W-1:0] tmo_ticks;
  logic [TIMEOUT_W-1:0] tmo_left;
  logic [7:0]           dev_addr_q;
  logic [7:0]           reg_addr_q;
  logic [7:0]           data_q;
  logic                 rd_op;
  phase_t               phase_q;
  logic [1:0]           op_st;
  logic                 ev_on;

  res_item_t due_results[$];

  function automatic res_item_t sequencer_step(input cmd_item_t it);
    res_item_t r;
    r = '0;
    case (it.command)
      CMD_READ: begin
        op_st      = OP_BUSY;
        dev_addr_q = it.device_addr;
        reg_addr_q = it.storage_addr;
        rd_op      = 1'b1;
        phase_q    = PH_DUMMY;
        r.start_request = 1'b1;
      end
      CMD_WRITE: begin
        dev_addr_q = it.device_addr;
        reg_addr_q = it.storage_addr;
        data_q     = it.write_data;
        op_st      = OP_BUSY;
        rd_op      = 1'b0;
        r.start_request = 1'b1;
      end
      CMD_TICK: begin
        if (tmo_left != '0) tmo_left = tmo_left - TIMEOUT_W'(1);
      end
      default: begin
        if (ev_on) begin
          case (it.bus_status)
            BS_START: begin
              r.start_clear = 1'b1;
              r.tx_valid    = 1'b1;
              r.tx_byte     = dev_addr_q & ADDR_WR_MASK;
              tmo_left      = tmo_ticks;
            end
            BS_REP_START: begin
              r.start_clear = 1'b1;
              r.tx_valid    = 1'b1;
              if (rd_op && phase_q != PH_DUMMY) r.tx_byte = dev_addr_q | ADDR_RD_BIT;
              else r.tx_byte = dev_addr_q & ADDR_WR_MASK;
            end
            BS_SLAW_ACK: begin
              r.tx_valid = 1'b1;
              r.tx_byte  = reg_addr_q;
              phase_q    = PH_DATA;
            end
            BS_SLAW_NACK: begin
              if (tmo_left == '0) begin
                r.stop_request = 1'b1;
                op_st = OP_ERROR;
              end else begin
                r.start_request = 1'b1;
              end
            end
            BS_DATA_ACK: begin
              if (phase_q == PH_LOWER) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = reg_addr_q;
                phase_q    = PH_DATA;
              end else if (phase_q == PH_DATA) begin
                if (rd_op) begin
                  r.start_request = 1'b1;
                end else begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = data_q;
                  phase_q    = PH_DONE;
                end
              end else if (phase_q == PH_DONE) begin
                r.stop_request = 1'b1;
                op_st = OP_OK;
              end
            end
            BS_DATA_NACK, BS_SLAR_NACK: begin
              r.stop_request = 1'b1;
              op_st = OP_ERROR;
            end
            BS_SLAR_ACK: begin
            end
            BS_RX_NACK: begin
              data_q = it.rx_data;
              op_st  = OP_OK;
              r.stop_request = 1'b1;
            end
            default: begin
              r.stop_request = 1'b1;
              op_st = OP_ERROR;
              ev_on = 1'b0;
            end
          endcase
        end
      end
    endcase
    r.op_status     = op_st;
    r.read_data     = data_q;
    r.events_masked = !ev_on;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    res_item_t got;
    if (rst) begin
      tmo_ticks  = TIMEOUT_RESET;
      tmo_left   = '0;
      dev_addr_q = '0;
      reg_addr_q = '0;
      data_q     = '0;
      rd_op      = 1'b0;
      phase_q    = PH_DUMMY;
      op_st      = OP_BUSY;
      ev_on      = 1'b1;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
        tmo_ticks = pwdata[TIMEOUT_W-1:0];
      // Results are registered and so leave after their item, so the oldest
      // expectation is settled before this edge's item is predicted.
      if (res.valid && res.ready) begin
        got = res.payload;
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("start_request", 8'(want.start_request), 8'(got.start_request));
          check_field("start_clear", 8'(want.start_clear), 8'(got.start_clear));
          check_field("stop_request", 8'(want.stop_request), 8'(got.stop_request));
          check_field("op_status", 8'(want.op_status), 8'(got.op_status));
          check_field("read_data", want.read_data, got.read_data);
          check_field("events_masked", 8'(want.events_masked), 8'(got.events_masked));
        end
      end
      if (cmd.valid && cmd.ready) due_results.push_back(sequencer_step(cmd.payload));
    end
    backlog <= due_results.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the testbench for the I2C register access master sequencer.
// Depends on i2cra_pkg, the channel interfaces, the block itself and i2cra_checker.
module tb_top;
  import i2cra_pkg::*;

  // Byte addresses on the APB port: the timeout register, and one slot above it
  // that decodes to no register at all and must be ignored.
  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'({REG_TIMEOUT, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR   = CFG_ADDR_W'(4);

  // Every status code the sequencer understands. Anything else masks all later
  // events for good, and reset is only applied once, so unknown codes are kept
  // back until the very end of the run.
  localparam logic [7:0] KNOWN_CODES [9] = '{
    BS_START, BS_REP_START, BS_SLAW_ACK, BS_SLAW_NACK, BS_DATA_ACK,
    BS_DATA_NACK, BS_SLAR_ACK, BS_SLAR_NACK, BS_RX_NACK
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned settings_run;
  // While set, neither side inserts gaps, so back-to-back traffic is covered too.
  bit          quiet;

  i2cra_cmd_if cmd_ch ();
  i2cra_res_if res_ch ();

  i2c_register_access_master_sequencer_core uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2cra_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_ch),
    .res          (res_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .backlog      (backlog),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap lengths for both sides: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one item after an optional gap and returns at the edge where it is
  // taken. The valid line is only lowered when a gap is due, so a run of
  // back-to-back items keeps it high throughout.
  task automatic send_item(input cmd_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_full(input command_t c, input logic [7:0] dev, input logic [7:0] sto,
                          input logic [7:0] wd, input logic [7:0] bs, input logic [7:0] rx);
    cmd_item_t it;
    it.command      = c;
    it.device_addr  = dev;
    it.storage_addr = sto;
    it.write_data   = wd;
    it.bus_status   = bs;
    it.rx_data      = rx;
    send_item(it);
  endtask

  // Random content everywhere; the status code only matters for bus events,
  // so for the other commands it is random as well.
  task automatic put(input command_t c, input logic [7:0] bs = 8'h00);
    logic [7:0] code;
    code = (c == CMD_EVENT) ? bs : 8'($urandom);
    put_full(c, 8'($urandom), 8'($urandom), 8'($urandom), code, 8'($urandom));
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(CMD_TICK);
  endtask

  // Address NACKs, each answered by a repeated start, with ticks in between.
  task automatic addr_retries(input int unsigned n);
    repeat (n) begin
      maybe_ticks();
      put(CMD_EVENT, BS_SLAW_NACK);
      put(CMD_EVENT, BS_REP_START);
    end
  endtask

  // Waits until every expected result has come back. The checker's backlog
  // count is registered, so a clock edge always passes before it is trusted.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle wait so that two writes in a row
  // never touch psel twice in the same time step.
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One random transaction. Most are complete register writes or reads with
  // random content, some run the retry timer down, and the rest are short bursts
  // of noise made of arbitrary commands and known status codes.
  task automatic random_transfer();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 36) begin
      put(CMD_WRITE);
      maybe_ticks();
      put(CMD_EVENT, BS_START);
      if ($urandom_range(0, 2) == 0) addr_retries($urandom_range(1, 3));
      put(CMD_EVENT, BS_SLAW_ACK);
      maybe_ticks();
      put(CMD_EVENT, BS_DATA_ACK);
      if ($urandom_range(0, 7) == 0) put(CMD_EVENT, BS_DATA_NACK);
      else put(CMD_EVENT, BS_DATA_ACK);
    end else if (r < 72) begin
      put(CMD_READ);
      put(CMD_EVENT, BS_START);
      if ($urandom_range(0, 2) == 0) addr_retries($urandom_range(1, 3));
      put(CMD_EVENT, BS_SLAW_ACK);
      put(CMD_EVENT, BS_DATA_ACK);
      maybe_ticks();
      put(CMD_EVENT, BS_REP_START);
      if ($urandom_range(0, 7) == 0) begin
        put(CMD_EVENT, BS_SLAR_NACK);
      end else begin
        put(CMD_EVENT, BS_SLAR_ACK);
        put(CMD_EVENT, BS_RX_NACK);
      end
    end else if (r < 80) begin
      // Tick the timer for a while with the odd retry, then NACK once more.
      // Short timeouts expire here; long ones keep retrying.
      put(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE);
      put(CMD_EVENT, BS_START);
      n = $urandom_range(0, 70);
      repeat (n) begin
        put(CMD_TICK);
        if ($urandom_range(0, 7) == 0) begin
          put(CMD_EVENT, BS_SLAW_NACK);
          put(CMD_EVENT, BS_REP_START);
        end
      end
      put(CMD_EVENT, BS_SLAW_NACK);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) != 0) put(CMD_EVENT, KNOWN_CODES[$urandom_range(0, 8)]);
        else put(command_t'($urandom_range(0, 3)), KNOWN_CODES[$urandom_range(0, 8)]);
      end
    end
  endtask

  // The receiving side stalls at random, with the same gap profile as the sender.
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] settings [6];
    int unsigned target;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    quiet           = 1'b0;
    items_sent      = 0;
    settings_run    = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the timeout at its reset value. A tick with the
    // counter at zero, and a data ACK while still in the dummy write phase,
    // both leave everything as it is.
    put(CMD_TICK);
    put(CMD_EVENT, BS_DATA_ACK);
    // A full register write with extreme field values.
    put_full(CMD_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
    put(CMD_EVENT, BS_START);
    put(CMD_EVENT, BS_SLAW_ACK);
    put(CMD_EVENT, BS_DATA_ACK);
    put(CMD_EVENT, BS_DATA_ACK);
    // A full register read with one address NACK and a retry.
    put_full(CMD_READ, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
    put(CMD_EVENT, BS_DATA_ACK);
    put(CMD_EVENT, BS_START);
    put(CMD_EVENT, BS_SLAW_NACK);
    put(CMD_TICK);
    put(CMD_EVENT, BS_REP_START);
    put(CMD_EVENT, BS_SLAW_ACK);
    put(CMD_EVENT, BS_DATA_ACK);
    put(CMD_EVENT, BS_REP_START);
    put(CMD_EVENT, BS_SLAR_ACK);
    put_full(CMD_EVENT, 8'h00, 8'h00, 8'h00, BS_RX_NACK, 8'hFF);
    // Error codes for a NACKed read address and a NACKed data byte.
    put(CMD_EVENT, BS_SLAR_NACK);
    put(CMD_EVENT, BS_DATA_NACK);
    // A start write keeps the phase from the read, so the next data ACK
    // sends the data byte straight away.
    put(CMD_WRITE);
    put(CMD_EVENT, BS_DATA_ACK);

    // With the timeout register at zero the first address NACK is fatal.
    drain();
    apb_write(TIMEOUT_ADDR, 32'h0000_0000);
    settings_run++;
    put(CMD_WRITE);
    put(CMD_EVENT, BS_START);
    put(CMD_EVENT, BS_SLAW_NACK);
    // A write to an address with no register behind it changes nothing.
    drain();
    apb_write(SPARE_ADDR, 32'h0000_1234);
    put(CMD_EVENT, BS_START);
    put(CMD_EVENT, BS_SLAW_NACK);

    // Random part: several timeout settings, the extremes among them and the
    // reset value once more. Upper bits of the write data are random.
    settings = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 40)), TIMEOUT_RESET,
                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 20))};
    foreach (settings[i]) begin
      drain();
      apb_write(TIMEOUT_ADDR, {16'($urandom), settings[i]});
      settings_run++;
      target = items_sent + 215;
      while (items_sent < target) begin
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        random_transfer();
      end
    end
    quiet = 1'b0;

    // Unknown status codes last of all: the first one masks every later event,
    // while start commands and ticks must still take effect.
    put(CMD_EVENT, 8'hFF);
    put(CMD_EVENT, 8'h00);
    put(CMD_WRITE);
    put(CMD_EVENT, BS_START);
    repeat (20) put(command_t'($urandom_range(0, 3)), 8'($urandom));

    drain();
    repeat (5) @(posedge clk);
    $display("Sent %0d items under %0d timeout settings; %0d result items compared.",
             items_sent, settings_run, results_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: 10 ms of simulated time, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/i2cra_pkg.sv
hdl/i2cra_if.sv
hdl/i2c_register_access_master_sequencer_core.sv
tb/i2cra_checker.sv
tb/tb_top.sv
